FILE: sv/cdec_pkg.sv
package cdec_pkg;

   // directory entry layout
   localparam int unsigned ENTRY_BYTES   = 32;
   localparam int unsigned POINTER_SLOTS = 16;
   localparam int unsigned MAP_BLOCKS    = 256;
   localparam int unsigned POS_W         = $clog2(ENTRY_BYTES);
   localparam int unsigned NEED_W        = 5;

   // byte positions inside one entry
   localparam logic [POS_W-1:0] POS_USER     = 5'd0;
   localparam logic [POS_W-1:0] POS_NAME0    = 5'd1;
   localparam logic [POS_W-1:0] POS_NAME_END = 5'd8;
   localparam logic [POS_W-1:0] POS_TYPE0    = 5'd9;
   localparam logic [POS_W-1:0] POS_TYPE_END = 5'd11;
   localparam logic [POS_W-1:0] POS_EXTENT   = 5'd12;
   localparam logic [POS_W-1:0] POS_S1       = 5'd13;
   localparam logic [POS_W-1:0] POS_S2       = 5'd14;
   localparam logic [POS_W-1:0] POS_RC       = 5'd15;
   localparam logic [POS_W-1:0] POS_LAST     = 5'd31;

   // field limits
   localparam logic [7:0] FREE_MARK  = 8'hE5;
   localparam logic [7:0] USER_MAX   = 8'd15;
   localparam logic [7:0] EXTENT_MAX = 8'd31;
   localparam logic [7:0] S1_MAX     = 8'd128;
   localparam logic [7:0] S2_MAX     = 8'd15;
   localparam logic [7:0] RC_MAX     = 8'd128;
   localparam logic [7:0] LIVE_MAX   = 8'hFF;
   localparam logic [6:0] CHAR_SPACE = 7'h20;
   localparam logic [6:0] CHAR_LOW   = 7'h21;
   localparam logic [6:0] CHAR_HIGH  = 7'h7E;

   // register indexes
   localparam logic CSR_LOW_BLOCK   = 1'b0;
   localparam logic CSR_DISK_BLOCKS = 1'b1;

   // register reset values
   localparam logic [7:0] LOW_BLOCK_RESET   = 8'd1;
   localparam logic [7:0] DISK_BLOCKS_RESET = 8'd175;

   typedef enum logic [1:0] {
      STATUS_FREE    = 2'd0,
      STATUS_LIVE    = 2'd1,
      STATUS_INVALID = 2'd2
   } cdec_status_type;

   typedef struct packed {
      cdec_status_type status;
      logic [7:0]      entry_number;
      logic [7:0]      live_count;
   } cdec_result_type;

   // printable and not one of the reserved punctuation marks
   function automatic logic allowed_char(input logic [6:0] c);
      logic ok;
      ok = (c >= CHAR_LOW) && (c <= CHAR_HIGH);
      if (c inside {7'h2E, 7'h2C, 7'h3B, 7'h3A, 7'h3D, 7'h3F, 7'h2A,
                    7'h3C, 7'h3E, 7'h5B, 7'h5D}) begin
         ok = 1'b0;
      end
      return ok;
   endfunction

endpackage

FILE: sv/cdec_core.sv
module cdec_core
   import cdec_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      data_byte,
   input  logic            restart,
   input  logic [7:0]      low_block,
   input  logic [7:0]      disk_blocks,
   output logic            result_valid,
   output cdec_result_type result
);

   logic [POS_W-1:0]      byte_position_ff, byte_position_in;
   logic [7:0]            entry_counter_ff, entry_counter_in;
   logic                  is_free_ff, is_free_in;
   logic                  is_bad_ff, is_bad_in;
   logic                  in_padding_ff, in_padding_in;
   logic                  extent_odd_ff, extent_odd_in;
   logic [NEED_W-1:0]     blocks_needed_ff, blocks_needed_in;
   logic [MAP_BLOCKS-1:0] block_map_ff, block_map_in;
   logic [7:0]            live_total_ff, live_total_in;

   logic [POS_W-1:0]      pos;
   logic [7:0]            live_base;
   logic [7:0]            counter_base;
   logic [6:0]            ch;
   logic                  pad_now;
   logic [9:0]            records_up;
   logic [NEED_W-1:0]     slot;
   cdec_status_type       status;

   // restart acts before the byte is used
   assign pos          = restart ? POS_USER : byte_position_ff;
   assign live_base    = restart ? 8'd0 : live_total_ff;
   assign counter_base = restart ? 8'd0 : entry_counter_ff;
   assign ch           = data_byte[6:0];
   assign records_up   = {2'b00, extent_odd_ff, 7'd0} + {2'b00, data_byte} + 10'd15;
   assign slot         = {1'b0, pos[3:0]};

   // per-byte checks and map update
   always_comb begin
      is_free_in       = is_free_ff;
      is_bad_in        = is_bad_ff;
      in_padding_in    = in_padding_ff;
      extent_odd_in    = extent_odd_ff;
      blocks_needed_in = blocks_needed_ff;
      block_map_in     = restart ? '0 : block_map_ff;
      pad_now          = in_padding_ff;
      if (pos == POS_USER) begin
         is_free_in       = (data_byte == FREE_MARK);
         is_bad_in        = (data_byte != FREE_MARK) && (data_byte > USER_MAX);
         in_padding_in    = 1'b0;
         extent_odd_in    = 1'b0;
         blocks_needed_in = '0;
      end else if (!is_free_ff && !is_bad_ff) begin
         if (pos <= POS_TYPE_END) begin
            // name and type characters, spaces only as trailing padding
            if (pos == POS_TYPE0) begin
               pad_now = 1'b0;
            end
            in_padding_in = pad_now;
            if (ch == CHAR_SPACE) begin
               if (pos == POS_NAME0) begin
                  is_bad_in = 1'b1;
               end
               in_padding_in = 1'b1;
            end else if (pad_now || !allowed_char(ch)) begin
               is_bad_in = 1'b1;
            end
         end else if (pos == POS_EXTENT) begin
            is_bad_in     = data_byte > EXTENT_MAX;
            extent_odd_in = data_byte[0];
         end else if (pos == POS_S1) begin
            is_bad_in = data_byte > S1_MAX;
         end else if (pos == POS_S2) begin
            is_bad_in = data_byte > S2_MAX;
         end else if (pos == POS_RC) begin
            is_bad_in        = data_byte > RC_MAX;
            blocks_needed_in = records_up[8:4];
         end else if (data_byte != 8'd0) begin
            // block pointer: in range, within the records, not yet used
            if (slot >= blocks_needed_ff || data_byte < low_block ||
                data_byte >= disk_blocks) begin
               is_bad_in = 1'b1;
            end else if (block_map_in[data_byte]) begin
               is_bad_in = 1'b1;
            end else begin
               block_map_in[data_byte] = 1'b1;
            end
         end
      end
   end

   // entry verdict on the last byte
   always_comb begin
      result_valid     = (pos == POS_LAST);
      byte_position_in = pos + 5'd1;
      live_total_in    = live_base;
      entry_counter_in = counter_base;
      if (is_free_in) begin
         status = STATUS_FREE;
      end else if (is_bad_in) begin
         status = STATUS_INVALID;
      end else begin
         status = STATUS_LIVE;
      end
      if (result_valid) begin
         entry_counter_in = counter_base + 8'd1;
         if (status == STATUS_LIVE && live_base != LIVE_MAX) begin
            live_total_in = live_base + 8'd1;
         end
      end
      result.status       = status;
      result.entry_number = counter_base;
      result.live_count   = live_total_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff <= '0;
         entry_counter_ff <= '0;
         is_free_ff       <= 1'b0;
         is_bad_ff        <= 1'b0;
         in_padding_ff    <= 1'b0;
         extent_odd_ff    <= 1'b0;
         blocks_needed_ff <= '0;
         block_map_ff     <= '0;
         live_total_ff    <= '0;
      end else if (step) begin
         byte_position_ff <= byte_position_in;
         entry_counter_ff <= entry_counter_in;
         is_free_ff       <= is_free_in;
         is_bad_ff        <= is_bad_in;
         in_padding_ff    <= in_padding_in;
         extent_odd_ff    <= extent_odd_in;
         blocks_needed_ff <= blocks_needed_in;
         block_map_ff     <= block_map_in;
         live_total_ff    <= live_total_in;
      end
   end

   // a restart leaves at most the block of that beat marked
   a_restart_clears_map: assert property (@(posedge clock) disable iff (reset)
      step && restart |=> $countones(block_map_ff) <= 1)
      else $error("allocation map not cleared by restart");

   // a finished entry leaves the position at the start of the next one
   a_entry_wraps: assert property (@(posedge clock) disable iff (reset)
      step && result_valid |=> byte_position_ff == POS_USER)
      else $error("byte position did not wrap after entry");

   // live count only grows between restarts
   a_live_monotonic: assert property (@(posedge clock) disable iff (reset)
      step && !restart |=> live_total_ff >= $past(live_total_ff))
      else $error("live count decreased without restart");

endmodule

FILE: sv/cpm_directory_entry_checker.sv
// CP/M directory entry checker
//
// Request channel (req_valid/req_ready): one directory byte per beat, entries
// of 32 bytes back to back. req_restart on a beat clears the allocation map,
// the live count, the entry number and the byte position before that byte.
// Response channel (rsp_valid/rsp_ready): one beat per entry, sent after the
// last byte of the entry: status (0 free, 1 live, 2 invalid), entry number
// since restart and the saturating live count including this entry.
// Config port (csr_write/csr_index/csr_wdata): index 0 lowest usable block,
// index 1 disk size in blocks; write only while the block is idle.
//
// Throughput is one byte per cycle while the response side keeps up: each byte
// needs only range compares and at most one read-modify-write of a single bit
// in the 256-bit allocation flops. rsp_valid rises once the last byte of an
// entry has left the input register and its verdict sits in the result register.
// Reset clears the map, counters and position and sets the lowest usable block
// to 1 and the disk size to 175 blocks. While the response side stalls, bytes
// that finish no entry keep flowing; a byte that finishes an entry waits until
// the result register frees up, and req_ready drops behind it.
module cpm_directory_entry_checker
   import cdec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_restart,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_entry_status,
   output logic [7:0] rsp_entry_number,
   output logic [7:0] rsp_live_count,
   input  logic       csr_write,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            in_restart_ff;
   logic [7:0]      low_block_ff;
   logic [7:0]      disk_blocks_ff;
   logic            rsp_valid_ff;
   cdec_result_type rsp_ff;

   logic            step;
   logic            core_valid;
   cdec_result_type core_result;

   // a byte moves on unless it finishes an entry and the result slot is taken
   assign step      = in_valid_ff && (!core_valid || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff    <= req_data_byte;
         in_restart_ff <= req_restart;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_block_ff   <= LOW_BLOCK_RESET;
         disk_blocks_ff <= DISK_BLOCKS_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_LOW_BLOCK:   low_block_ff   <= csr_wdata;
            CSR_DISK_BLOCKS: disk_blocks_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   cdec_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .data_byte    (in_byte_ff),
      .restart      (in_restart_ff),
      .low_block    (low_block_ff),
      .disk_blocks  (disk_blocks_ff),
      .result_valid (core_valid),
      .result       (core_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step && core_valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step && core_valid) begin
         rsp_ff <= core_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_entry_status = rsp_ff.status;
   assign rsp_entry_number = rsp_ff.entry_number;
   assign rsp_live_count   = rsp_ff.live_count;

   // a finished entry never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      step && core_valid |-> !rsp_valid_ff || rsp_ready)
      else $error("result register overwritten while stalled");

   // a new response beat always comes from a finished entry
   a_rsp_from_entry: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(step && core_valid))
      else $error("response beat without a finished entry");

endmodule

FILE: verif/tb_cpm_directory_entry_checker.sv
`timescale 1ns / 100ps

module tb_cpm_directory_entry_checker;
   import cdec_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int RESET_CYCLES = 5;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE_CYCLES = 6;
   localparam int DRAIN_LIMIT  = 2000;
   localparam int LONG_HOLD    = 300;
   localparam logic [8:0] RECORDS_PER_EXTENT = 9'd128;
   localparam logic [8:0] RECORDS_PER_BLOCK  = 9'd16;
   localparam logic [7:0] SPACE_BYTE = {1'b0, CHAR_SPACE};

   typedef struct packed {
      logic [7:0] data;
      logic       restart;
   } dir_beat_type;

   // dut ports, all inputs known from time zero
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = '0;
   logic       req_restart = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_entry_status;
   logic [7:0] rsp_entry_number;
   logic [7:0] rsp_live_count;
   logic       csr_write = 1'b0;
   logic       csr_index = 1'b0;
   logic [7:0] csr_wdata = '0;

   cpm_directory_entry_checker u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_entry_status (rsp_entry_status),
      .rsp_entry_number (rsp_entry_number),
      .rsp_live_count   (rsp_live_count),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // directory scan state mirrored from the block
   logic [7:0]   cfg_low_block = LOW_BLOCK_RESET;
   logic [7:0]   cfg_disk_blocks = DISK_BLOCKS_RESET;
   logic [4:0]   dir_pos = '0;
   logic [7:0]   dir_entry_num = '0;
   logic         ent_free = 1'b0;
   logic         ent_bad = 1'b0;
   logic         name_pad = 1'b0;
   logic         ext_odd = 1'b0;
   logic [4:0]   need_slots = '0;
   logic [255:0] used_blocks = '0;
   logic [7:0]   live_seen = '0;

   cdec_result_type entry_verdicts[$];
   dir_beat_type    pending_beats[$];

   // stimulus building
   logic [7:0]   draft[32];
   logic [255:0] handed_blocks = '0;

   int errors = 0;
   int cycle_count = 0;
   int beats_sent = 0;
   int seen_free = 0;
   int seen_live = 0;
   int seen_bad = 0;
   int hold_requests = 0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0d] mismatch on %s: got %0d, want %0d", cycle_count, what, got, want);
      errors++;
   endtask

   function automatic logic name_char_ok(input logic [6:0] c);
      case ({1'b0, c})
         ".", ",", ";", ":", "=", "?", "*", "<", ">", "[", "]": return 1'b0;
         default: return (c >= CHAR_LOW) && (c <= CHAR_HIGH);
      endcase
   endfunction

   // name and type bytes: spaces only as trailing padding
   task automatic check_name_char(input logic [7:0] raw, input logic first);
      logic [6:0] c;
      c = raw[6:0];
      if (c == CHAR_SPACE) begin
         if (first) ent_bad = 1'b1;
         name_pad = 1'b1;
      end else if (name_pad || !name_char_ok(c)) begin
         ent_bad = 1'b1;
      end
   endtask

   task automatic check_block_pointer(input logic [3:0] slot, input logic [7:0] blk);
      if (blk == 8'd0) return;
      if (slot >= need_slots || blk < cfg_low_block || blk >= cfg_disk_blocks) begin
         ent_bad = 1'b1;
      end else if (used_blocks[blk]) begin
         ent_bad = 1'b1;
      end else begin
         used_blocks[blk] = 1'b1;
      end
   endtask

   // advance the scan by one accepted byte, queue the verdict at entry end
   task automatic track_directory_byte(input logic [7:0] b, input logic rst);
      logic [4:0]      p;
      logic [8:0]      recs;
      logic [8:0]      rounded;
      cdec_result_type v;
      if (rst) begin
         used_blocks = '0;
         live_seen = '0;
         dir_entry_num = '0;
         dir_pos = '0;
      end
      p = dir_pos;
      if (p == POS_USER) begin
         ent_free = (b == FREE_MARK);
         ent_bad = !ent_free && (b > USER_MAX);
         name_pad = 1'b0;
         ext_odd = 1'b0;
         need_slots = '0;
      end else if (!ent_free && !ent_bad) begin
         if (p <= POS_NAME_END) begin
            check_name_char(b, p == POS_NAME0);
         end else if (p <= POS_TYPE_END) begin
            if (p == POS_TYPE0) name_pad = 1'b0;
            check_name_char(b, 1'b0);
         end else if (p == POS_EXTENT) begin
            if (b > EXTENT_MAX) ent_bad = 1'b1;
            ext_odd = b[0];
         end else if (p == POS_S1) begin
            if (b > S1_MAX) ent_bad = 1'b1;
         end else if (p == POS_S2) begin
            if (b > S2_MAX) ent_bad = 1'b1;
         end else if (p == POS_RC) begin
            if (b > RC_MAX) ent_bad = 1'b1;
            recs = (ext_odd ? RECORDS_PER_EXTENT : 9'd0) + {1'b0, b};
            rounded = recs + RECORDS_PER_BLOCK - 9'd1;
            need_slots = rounded[8:4];
         end else begin
            // pointer bytes sit at positions 16..31, slot is the low nibble
            check_block_pointer(p[3:0], b);
         end
      end
      dir_pos = p + 5'd1;
      if (p == POS_LAST) begin
         if (ent_free) begin
            v.status = STATUS_FREE;
         end else if (ent_bad) begin
            v.status = STATUS_INVALID;
         end else begin
            v.status = STATUS_LIVE;
            if (live_seen != LIVE_MAX) live_seen = live_seen + 8'd1;
         end
         v.entry_number = dir_entry_num;
         v.live_count = live_seen;
         entry_verdicts.push_back(v);
         dir_entry_num = dir_entry_num + 8'd1;
      end
   endtask

   // sender: bursts of random length with random gaps
   int           burst_left = 1;
   int           gap_left = 0;
   dir_beat_type next_beat;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            track_directory_byte(req_data_byte, req_restart);
            beats_sent++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0 || pending_beats.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_valid <= 1'b0;
            end else begin
               next_beat = pending_beats.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= next_beat.data;
               req_restart <= next_beat.restart;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 48);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   // receiver: changing stall modes, plus long hold-offs on request
   int         hold_left = 0;
   int         holds_done = 0;
   int         mode_left = 0;
   int         ready_mode = 0;
   logic [7:0] ready_pattern = 8'hFF;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (holds_done != hold_requests) begin
         holds_done++;
         hold_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left <= 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
            ready_pattern = 8'($urandom_range(1, 255));
         end
         mode_left--;
         case (ready_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 1);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: begin
               rsp_ready <= ready_pattern[0];
               ready_pattern = {ready_pattern[0], ready_pattern[7:1]};
            end
         endcase
      end
   end

   // result check against the oldest verdict
   cdec_result_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (entry_verdicts.size() == 0) begin
            report_mismatch("unexpected result, entry number", rsp_entry_number, -1);
         end else begin
            want = entry_verdicts.pop_front();
            if (rsp_entry_status != want.status)
               report_mismatch("entry_status", rsp_entry_status, want.status);
            if (rsp_entry_number != want.entry_number)
               report_mismatch("entry_number", rsp_entry_number, want.entry_number);
            if (rsp_live_count != want.live_count)
               report_mismatch("live_count", rsp_live_count, want.live_count);
            case (want.status)
               STATUS_FREE: seen_free++;
               STATUS_LIVE: seen_live++;
               default: seen_bad++;
            endcase
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  entry_verdicts.size());
         $display("status: fail");
         $finish;
      end
   end

   task automatic write_reg(input logic idx, input logic [7:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_LOW_BLOCK) cfg_low_block = value;
      else cfg_disk_blocks = value;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      while (pending_beats.size() != 0 || req_valid || entry_verdicts.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic queue_bytes(input int count, input logic rst_first);
      dir_beat_type b;
      if (rst_first) handed_blocks = '0;
      for (int i = 0; i < count; i++) begin
         b.data = draft[5'(i)];
         b.restart = rst_first && (i == 0);
         pending_beats.push_back(b);
      end
   endtask

   // plain live entry: name "A", blank type, no records, no pointers
   task automatic start_entry(input logic [7:0] user);
      draft[POS_USER] = user;
      draft[POS_NAME0] = "A";
      for (int i = 2; i < 12; i++) draft[5'(i)] = SPACE_BYTE;
      for (int i = 12; i < 32; i++) draft[5'(i)] = 8'd0;
   endtask

   function automatic logic [7:0] rand_name_char();
      logic [6:0] c;
      logic       hi;
      hi = 1'($urandom_range(0, 1));
      do c = 7'($urandom_range(CHAR_LOW, CHAR_HIGH)); while (!name_char_ok(c));
      return {hi, c};
   endfunction

   function automatic logic [7:0] rand_pad();
      logic hi;
      hi = 1'($urandom_range(0, 1));
      return {hi, CHAR_SPACE};
   endfunction

   function automatic logic [7:0] forbidden_char();
      case ($urandom_range(0, 10))
         0: return ".";
         1: return ",";
         2: return ";";
         3: return ":";
         4: return "=";
         5: return "?";
         6: return "*";
         7: return "<";
         8: return ">";
         9: return "[";
         default: return "]";
      endcase
   endfunction

   // block in the legal range if it is not empty, preferring ones not yet handed out
   function automatic logic [7:0] pick_block();
      logic [7:0] blk;
      blk = 8'($urandom_range(0, 255));
      if (cfg_disk_blocks > cfg_low_block) begin
         for (int t = 0; t < 4; t++) begin
            blk = 8'($urandom_range(cfg_low_block, cfg_disk_blocks - 1));
            if (!handed_blocks[blk]) break;
         end
      end
      handed_blocks[blk] = 1'b1;
      return blk;
   endfunction

   task automatic build_random_entry();
      int         kind;
      int         nlen;
      int         tlen;
      logic [8:0] recs;
      int         need;
      for (int i = 0; i < 32; i++) draft[5'(i)] = 8'($urandom_range(0, 255));
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
         draft[POS_USER] = FREE_MARK;
         return;
      end
      // raw garbage entries
      if (kind < 14) return;
      draft[POS_USER] = 8'($urandom_range(0, USER_MAX));
      nlen = $urandom_range(1, 8);
      tlen = $urandom_range(0, 3);
      for (int i = 0; i < 8; i++)
         draft[POS_NAME0 + 5'(i)] = (i < nlen) ? rand_name_char() : rand_pad();
      for (int i = 0; i < 3; i++)
         draft[POS_TYPE0 + 5'(i)] = (i < tlen) ? rand_name_char() : rand_pad();
      if ($urandom_range(0, 15) == 0)
         draft[5'($urandom_range(POS_NAME0, POS_TYPE_END))] = forbidden_char();
      draft[POS_EXTENT] = 8'($urandom_range(0, EXTENT_MAX));
      draft[POS_S1] = 8'($urandom_range(0, S1_MAX));
      draft[POS_S2] = 8'($urandom_range(0, S2_MAX));
      draft[POS_RC] = 8'($urandom_range(0, RC_MAX));
      recs = (draft[POS_EXTENT][0] ? RECORDS_PER_EXTENT : 9'd0) + {1'b0, draft[POS_RC]};
      need = (recs + RECORDS_PER_BLOCK - 1) / RECORDS_PER_BLOCK;
      for (int s = 0; s < 16; s++)
         draft[5'(16 + s)] = (s < need && $urandom_range(0, 3) != 0) ? pick_block() : 8'd0;
      // stray pointer in a random slot, possibly past the records
      if ($urandom_range(0, 19) == 0)
         draft[5'(16 + $urandom_range(0, 15))] = 8'($urandom_range(1, 255));
      // one corrupted byte
      if (kind >= 88) draft[5'($urandom_range(0, 31))] = 8'($urandom_range(0, 255));
   endtask

   task automatic run_random(input int entries);
      logic rst_next;
      rst_next = 1'b1;
      for (int e = 0; e < entries; e++) begin
         build_random_entry();
         if ($urandom_range(0, 24) == 0) begin
            // broken entry cut short by a restart
            queue_bytes($urandom_range(1, 31), rst_next);
            rst_next = 1'b1;
            build_random_entry();
         end
         queue_bytes(32, rst_next || ($urandom_range(0, 7) == 0));
         rst_next = 1'b0;
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed entries at reset register values
      for (int i = 0; i < 32; i++) draft[5'(i)] = 8'($urandom_range(0, 255));
      draft[POS_USER] = FREE_MARK;
      queue_bytes(32, 1'b0);
      // basic live entry, high-bit space as padding
      start_entry(8'd0);
      draft[3] = {1'b1, CHAR_SPACE};
      draft[POS_TYPE0] = "C"; draft[10] = "O"; draft[11] = "M";
      draft[POS_RC] = 8'd16;
      draft[16] = cfg_low_block;
      queue_bytes(32, 1'b0);
      // every field at its upper limit, 16 pointers
      start_entry(USER_MAX);
      draft[1] = 8'h21; draft[2] = 8'hC1; draft[3] = "Z"; draft[4] = "a";
      draft[5] = "z"; draft[6] = "0"; draft[7] = 8'hB9; draft[8] = 8'h7E;
      draft[9] = "T"; draft[10] = 8'hD8; draft[11] = "~";
      draft[POS_EXTENT] = EXTENT_MAX; draft[POS_S1] = S1_MAX;
      draft[POS_S2] = S2_MAX; draft[POS_RC] = RC_MAX;
      for (int s = 0; s < 16; s++)
         draft[5'(16 + s)] = (s == 0) ? cfg_disk_blocks - 8'd1 : 8'(s + 1);
      queue_bytes(32, 1'b0);
      // user above limit
      start_entry(USER_MAX + 8'd1);
      queue_bytes(32, 1'b0);
      // blank name
      start_entry(8'd1); draft[POS_NAME0] = SPACE_BYTE;
      queue_bytes(32, 1'b0);
      // space inside the name
      start_entry(8'd2); draft[3] = "B";
      queue_bytes(32, 1'b0);
      // forbidden punctuation in type
      start_entry(8'd3); draft[POS_TYPE0] = ".";
      queue_bytes(32, 1'b0);
      // record count just above its limit
      start_entry(8'd5); draft[POS_RC] = RC_MAX + 8'd1;
      queue_bytes(32, 1'b0);
      // pointer beyond the records needed
      start_entry(8'd6); draft[POS_RC] = 8'd16; draft[17] = 8'd20;
      queue_bytes(32, 1'b0);
      // pointer at the disk size
      start_entry(8'd6); draft[POS_RC] = 8'd16; draft[16] = cfg_disk_blocks;
      queue_bytes(32, 1'b0);
      // block already taken
      start_entry(8'd7); draft[POS_RC] = 8'd16; draft[16] = cfg_disk_blocks - 8'd1;
      queue_bytes(32, 1'b0);
      // marking stops once invalid, earlier marks stay
      start_entry(8'd7); draft[POS_RC] = 8'd64;
      draft[16] = 8'd40; draft[17] = 8'd200; draft[18] = 8'd41;
      queue_bytes(32, 1'b0);
      start_entry(8'd7); draft[POS_RC] = 8'd32; draft[16] = 8'd41; draft[17] = 8'd40;
      queue_bytes(32, 1'b0);
      // odd extent with no records needs eight blocks
      start_entry(8'd8); draft[POS_EXTENT] = 8'd1; draft[23] = 8'd50;
      queue_bytes(32, 1'b0);
      // restart in the middle of an entry, then reuse a freed block
      start_entry(8'd9);
      queue_bytes(10, 1'b0);
      start_entry(8'd9); draft[POS_RC] = 8'd16; draft[16] = cfg_disk_blocks - 8'd1;
      queue_bytes(32, 1'b1);
      wait_idle();

      // widest block range
      write_reg(CSR_LOW_BLOCK, 8'd0);
      write_reg(CSR_DISK_BLOCKS, 8'd255);
      @(negedge clock);
      start_entry(8'd0); draft[POS_RC] = 8'd32; draft[16] = 8'd254; draft[17] = 8'd0;
      queue_bytes(32, 1'b1);
      start_entry(8'd0); draft[POS_RC] = 8'd16; draft[16] = 8'd255;
      queue_bytes(32, 1'b0);
      run_random(1);
      wait_idle();

      // empty block ranges
      write_reg(CSR_LOW_BLOCK, 8'd255);
      write_reg(CSR_DISK_BLOCKS, 8'd0);
      @(negedge clock);
      start_entry(8'd0); draft[POS_RC] = 8'd16; draft[16] = 8'd255;
      queue_bytes(32, 1'b1);
      run_random(1);
      wait_idle();
      write_reg(CSR_LOW_BLOCK, 8'd100);
      write_reg(CSR_DISK_BLOCKS, 8'd100);
      @(negedge clock);
      run_random(1);
      wait_idle();

      // narrow range near the top
      write_reg(CSR_LOW_BLOCK, 8'd200);
      write_reg(CSR_DISK_BLOCKS, 8'd255);
      @(negedge clock);
      run_random(1);
      wait_idle();

      // random range, one long response hold-off while bytes keep coming
      write_reg(CSR_LOW_BLOCK, 8'($urandom_range(1, 40)));
      write_reg(CSR_DISK_BLOCKS, 8'($urandom_range(120, 255)));
      @(negedge clock);
      run_random(2);
      hold_requests++;

      // drain: everything accepted, then every verdict back
      @(negedge clock);
      while (pending_beats.size() != 0 || req_valid) @(negedge clock);
      for (int w = 0; w < DRAIN_LIMIT && entry_verdicts.size() != 0; w++) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (entry_verdicts.size() != 0)
         report_mismatch("results never returned", 0, entry_verdicts.size());

      $display("covered %0d bytes, %0d entries: %0d free, %0d live, %0d invalid", beats_sent,
               seen_free + seen_live + seen_bad, seen_free, seen_live, seen_bad);
      $display("six block ranges incl. empty ones, idle pauses, long response hold-off");
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
